[rtl/rsws_pkg.sv]
// Shared types and constants for the range split work stealer.
// No dependencies.
package rsws_pkg;

    localparam int unsigned WD_BITS = 6;
    localparam int unsigned WC_BITS = 5;
    localparam logic [WD_BITS-1:0] WD_MAX = 6'd63;

    typedef enum logic [2:0] {
        VERDICT_NONE     = 3'd0,
        VERDICT_START    = 3'd1,
        VERDICT_FINISHED = 3'd2,
        VERDICT_RESPAWN  = 3'd3,
        VERDICT_RUN      = 3'd4
    } verdict_t;

    typedef enum logic [2:0] {
        CFG_WORKER_COUNT = 3'd0,
        CFG_JOB_OFFSET   = 3'd1,
        CFG_JOB_LENGTH   = 3'd2,
        CFG_MIN_SPLIT    = 3'd3,
        CFG_RESPAWN      = 3'd4,
        CFG_SAVE_INT     = 3'd5
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BUSY,
        ST_SCAN,
        ST_DIVIDE,
        ST_DECIDE,
        ST_OUTPUT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture request
        logic busy_poll;  // perform busy poll update
        logic scan_clear; // start scan
        logic scan_step;  // examine one worker
        logic div_start;
        logic div_step;
        logic decide;     // commit idle-poll result
        logic out_clear;  // result taken
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_poll;
        logic is_done;
        logic is_busy;
        logic scan_last;
        logic div_last;
        logic all_fresh;
    } ctrl_stat_t;

endpackage

[rtl/rsws_ctrl.sv]
// Controller state machine of the range split work stealer.
// Depends on rsws_pkg.
module rsws_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  rsws_pkg::ctrl_stat_t stat,
    output rsws_pkg::ctrl_cmd_t  cmd
);

    rsws_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rsws_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            rsws_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = rsws_pkg::ST_BUSY;
                end
            end
            rsws_pkg::ST_BUSY:
            begin
                // decode the captured request
                if (!stat.is_poll || stat.is_done)
                begin
                    state_next = rsws_pkg::ST_OUTPUT;
                end
                else if (stat.is_busy)
                begin
                    cmd.busy_poll = 1'b1;
                    state_next    = rsws_pkg::ST_OUTPUT;
                end
                else
                begin
                    cmd.scan_clear = 1'b1;
                    state_next     = rsws_pkg::ST_SCAN;
                end
            end
            rsws_pkg::ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (stat.scan_last)
                begin
                    state_next = rsws_pkg::ST_DIVIDE;
                end
            end
            rsws_pkg::ST_DIVIDE:
            begin
                if (stat.all_fresh)
                begin
                    state_next = rsws_pkg::ST_DECIDE;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = rsws_pkg::ST_DECIDE;
                end
            end
            rsws_pkg::ST_DECIDE:
            begin
                if (!stat.all_fresh && !stat.div_last)
                begin
                    cmd.div_step = 1'b1;
                end
                else
                begin
                    cmd.decide = 1'b1;
                    state_next = rsws_pkg::ST_OUTPUT;
                end
            end
            rsws_pkg::ST_OUTPUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    cmd.out_clear = 1'b1;
                    state_next    = rsws_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rsws_pkg::ST_IDLE;
            end
        endcase
    end

`ifndef SYNTH
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid) else $error("ready while result pending");
    a_scan_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(cmd.scan_step) |-> $past(cmd.scan_clear))
        else $error("scan began without clear");
    a_load_once: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> !in_ready) else $error("second load");
`endif

endmodule

[rtl/rsws_dp.sv]
// Datapath of the range split work stealer: worker table, scan, divider.
// Depends on rsws_pkg.
module rsws_dp #(
    parameter int unsigned WORKERS  = 16,
    parameter int unsigned LEN_BITS = 48
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  rsws_pkg::ctrl_cmd_t   cmd,
    output rsws_pkg::ctrl_stat_t  stat,
    input  logic                  in_kind,
    input  logic [3:0]            in_worker_id,
    input  logic [LEN_BITS-1:0]   in_offset,
    input  logic [LEN_BITS-1:0]   in_length,
    input  logic                  in_exit,
    input  logic [4:0]            worker_count,
    input  logic [LEN_BITS-1:0]   job_offset,
    input  logic [LEN_BITS-1:0]   job_length,
    input  logic [LEN_BITS-1:0]   min_split_size,
    input  logic [5:0]            respawn_limit,
    input  logic [5:0]            save_interval,
    input  logic [5:0]            save_reset,
    output logic [2:0]            verdict,
    output logic                  save_request,
    output logic                  split_made,
    output logic [3:0]            donor_id,
    output logic [LEN_BITS-1:0]   given_offset,
    output logic [LEN_BITS-1:0]   given_length,
    output logic [LEN_BITS-1:0]   donor_length
);

    localparam int unsigned IDX_BITS = (WORKERS > 1) ? $clog2(WORKERS) : 1;
    localparam int unsigned CNT_BITS = $clog2(WORKERS + 1);
    localparam int unsigned DIV_BITS = $clog2(LEN_BITS + 1);

    logic [LEN_BITS-1:0] start_reg [WORKERS];
    logic [LEN_BITS-1:0] left_reg  [WORKERS];
    logic [LEN_BITS-1:0] seen_reg  [WORKERS];
    logic [5:0]          wd_reg    [WORKERS];
    logic [WORKERS-1:0]  done_reg;
    logic [5:0]          save_cnt_reg;

    logic                kind_reg, exit_reg, valid_id_reg;
    logic [IDX_BITS-1:0] idx_reg;
    logic [LEN_BITS-1:0] off_reg, len_reg;

    logic [IDX_BITS-1:0] scan_reg;
    logic [CNT_BITS-1:0] n_reg, idle_reg, fresh_reg;
    logic [LEN_BITS-1:0] most_reg;
    logic [IDX_BITS-1:0] best_reg;

    logic [LEN_BITS-1:0] quot_reg, rem_reg;
    logic [CNT_BITS:0]   divisor_reg;
    logic [DIV_BITS-1:0] div_cnt_reg;

    logic [2:0]          verdict_reg;
    logic                save_reg, split_reg;
    logic [3:0]          donor_reg;
    logic [LEN_BITS-1:0] goff_reg, glen_reg, dlen_reg;

    logic [CNT_BITS-1:0] n_use;
    logic [LEN_BITS:0]   rem_shift;
    logic [LEN_BITS:0]   rem_sub;
    logic [5:0]          wd_cur;
    logic                wd_check, respawn;
    logic                prog_write;
    logic                decode_reg;

    always_comb
    begin
        if (worker_count == 5'd0)
            n_use = CNT_BITS'(1);
        else if (32'(worker_count) > WORKERS)
            n_use = CNT_BITS'(WORKERS);
        else
            n_use = CNT_BITS'(worker_count);
    end

    assign rem_shift = {rem_reg, quot_reg[LEN_BITS-1]};
    assign rem_sub   = rem_shift - (LEN_BITS+1)'(divisor_reg);
    assign wd_cur    = wd_reg[idx_reg];
    assign wd_check  = (wd_cur > respawn_limit) || (wd_cur == 6'd0);
    assign respawn   = wd_check && (seen_reg[idx_reg] != '0)
                       && !(seen_reg[idx_reg] > left_reg[idx_reg]);

    assign stat.is_poll   = kind_reg && valid_id_reg;
    assign stat.is_done   = done_reg[idx_reg];
    assign stat.is_busy   = left_reg[idx_reg] != '0;
    assign stat.scan_last = (32'(scan_reg) + 1) >= 32'(n_reg);
    assign stat.div_last  = div_cnt_reg == '0;
    assign stat.all_fresh = fresh_reg == n_reg;

    // capture and scan
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg     <= in_kind;
            exit_reg     <= in_exit;
            valid_id_reg <= 32'(in_worker_id) < WORKERS;
            idx_reg      <= IDX_BITS'(in_worker_id);
            off_reg      <= in_offset;
            len_reg      <= in_length;
        end
        if (cmd.scan_clear)
        begin
            scan_reg  <= '0;
            n_reg     <= n_use;
            idle_reg  <= '0;
            fresh_reg <= '0;
            most_reg  <= '0;
            best_reg  <= '0;
        end
        else if (cmd.scan_step)
        begin
            scan_reg <= scan_reg + 1'b1;
            if (left_reg[scan_reg] == '0)
            begin
                idle_reg <= idle_reg + 1'b1;
                if (start_reg[scan_reg] == '0)
                    fresh_reg <= fresh_reg + 1'b1;
            end
            if (left_reg[scan_reg] > most_reg)
            begin
                most_reg <= left_reg[scan_reg];
                best_reg <= scan_reg;
            end
        end
        // restoring division, one quotient bit per cycle
        if (cmd.div_start)
        begin
            quot_reg    <= most_reg;
            rem_reg     <= '0;
            divisor_reg <= (CNT_BITS+1)'(idle_reg) + 1'b1;
            div_cnt_reg <= DIV_BITS'(LEN_BITS);
        end
        else if (cmd.div_step)
        begin
            div_cnt_reg <= div_cnt_reg - 1'b1;
            if (!rem_sub[LEN_BITS])
            begin
                rem_reg  <= rem_sub[LEN_BITS-1:0];
                quot_reg <= {quot_reg[LEN_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_shift[LEN_BITS-1:0];
                quot_reg <= {quot_reg[LEN_BITS-2:0], 1'b0};
            end
        end
    end

    // worker table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WORKERS; i++)
            begin
                start_reg[i] <= '0;
                left_reg[i]  <= '0;
                seen_reg[i]  <= '0;
                wd_reg[i]    <= '0;
            end
            done_reg     <= '0;
            save_cnt_reg <= save_reset;
            verdict_reg  <= rsws_pkg::VERDICT_NONE;
            save_reg     <= 1'b0;
            split_reg    <= 1'b0;
            donor_reg    <= '0;
            goff_reg     <= '0;
            glen_reg     <= '0;
            dlen_reg     <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                verdict_reg <= rsws_pkg::VERDICT_NONE;
                save_reg    <= 1'b0;
                split_reg   <= 1'b0;
                donor_reg   <= '0;
                goff_reg    <= '0;
                glen_reg    <= '0;
                dlen_reg    <= '0;
            end
            if (cmd.busy_poll)
            begin
                if (save_cnt_reg >= save_interval)
                begin
                    save_cnt_reg <= '0;
                    save_reg     <= 1'b1;
                end
                else
                begin
                    save_cnt_reg <= save_cnt_reg + 1'b1;
                end
                if (wd_check && !respawn)
                    seen_reg[idx_reg] <= left_reg[idx_reg];
                if (respawn)
                begin
                    wd_reg[idx_reg] <= 6'd1;
                    verdict_reg     <= rsws_pkg::VERDICT_RESPAWN;
                end
                else
                begin
                    if (wd_check)
                        wd_reg[idx_reg] <= 6'd2;
                    else if (wd_cur < rsws_pkg::WD_MAX)
                        wd_reg[idx_reg] <= wd_cur + 1'b1;
                    if (exit_reg)
                    begin
                        save_reg          <= 1'b1;
                        done_reg[idx_reg] <= 1'b1;
                        verdict_reg       <= rsws_pkg::VERDICT_FINISHED;
                    end
                    else if (wd_cur == 6'd0)
                    begin
                        verdict_reg <= rsws_pkg::VERDICT_START;
                    end
                end
            end
            if (prog_write)
            begin
                start_reg[idx_reg] <= off_reg;
                left_reg[idx_reg]  <= len_reg;
            end
            if (cmd.decide)
            begin
                save_reg <= 1'b1;
                if (stat.all_fresh)
                begin
                    start_reg[idx_reg] <= job_offset;
                    left_reg[idx_reg]  <= job_length;
                    verdict_reg        <= rsws_pkg::VERDICT_RUN;
                    split_reg          <= 1'b1;
                    goff_reg           <= job_offset;
                    glen_reg           <= job_length;
                end
                else if (quot_reg > min_split_size)
                begin
                    start_reg[idx_reg]  <= start_reg[best_reg] + quot_reg;
                    left_reg[idx_reg]   <= most_reg - quot_reg;
                    left_reg[best_reg]  <= quot_reg;
                    verdict_reg         <= rsws_pkg::VERDICT_RUN;
                    split_reg           <= 1'b1;
                    donor_reg           <= 4'(best_reg);
                    goff_reg            <= start_reg[best_reg] + quot_reg;
                    glen_reg            <= most_reg - quot_reg;
                    dlen_reg            <= quot_reg;
                end
                else
                begin
                    done_reg[idx_reg] <= 1'b1;
                    verdict_reg       <= rsws_pkg::VERDICT_FINISHED;
                end
            end
        end
    end

    // a progress report is written once, in the decode cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            decode_reg <= 1'b0;
        else
            decode_reg <= cmd.load;
    end
    assign prog_write = decode_reg && !kind_reg && valid_id_reg;

    assign verdict      = verdict_reg;
    assign save_request = save_reg;
    assign split_made   = split_reg;
    assign donor_id     = donor_reg;
    assign given_offset = goff_reg;
    assign given_length = glen_reg;
    assign donor_length = dlen_reg;

`ifndef SYNTH
    a_one_action: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.busy_poll && cmd.decide)) else $error("two commits");
    a_split_share: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.decide && !stat.all_fresh |-> stat.div_last)
        else $error("decide before divide finished");
    a_done_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_clear && split_made |-> verdict == rsws_pkg::VERDICT_RUN)
        else $error("split without run verdict");
`endif

endmodule

[rtl/range_split_work_stealer.sv]
// Top level of the range split work stealer.
// Depends on rsws_pkg, rsws_ctrl and rsws_dp.
//
// Usage: one request enters on s_axis (tdata as below, tuser = kind);
// exactly one result leaves on m_axis per request. Configuration is
// written through cfg_we/cfg_index/cfg_data; the user must do so only while
// the block is idle, which the block itself does not enforce. A progress
// report or a busy poll goes from acceptance through the decode state to
// the result on m_axis; an idle poll scans the workers in use one a cycle
// and then runs a restoring divide of LEN_BITS steps, which is skipped
// when the whole job is handed out.
// One request is handled at a time; s_axis_tready is low from acceptance
// until the result is taken and rises the cycle after. When the receiver
// stalls the result holds on m_axis and no new request is taken.
// Reset clears the worker table and finished marks, sets the config and
// result registers to defaults, and loads the snapshot counter's reset value.
module range_split_work_stealer #(
    parameter int unsigned WORKERS  = 16,
    parameter int unsigned LEN_BITS = 48
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // worker_id[3:0], report_offset, report_length, exit_request, zero pad
    input  logic [((2*LEN_BITS+12)/8)*8-1:0]    s_axis_tdata,
    // kind
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // verdict[2:0], save_request, split_made, donor_id[3:0],
    // given_offset, given_length, donor_length, zero pad
    output logic [((3*LEN_BITS+16)/8)*8-1:0]    m_axis_tdata,
    input  logic                                cfg_we,
    input  logic [2:0]                          cfg_index,
    input  logic [LEN_BITS-1:0]                 cfg_data
);

    localparam int unsigned OUT_W = ((3*LEN_BITS+16)/8)*8;

    logic [4:0]          worker_count_reg;
    logic [LEN_BITS-1:0] job_offset_reg, job_length_reg, min_split_reg;
    logic [5:0]          respawn_reg, save_int_reg;

    // hold the configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            worker_count_reg <= 5'd1;
            job_offset_reg   <= '0;
            job_length_reg   <= '0;
            min_split_reg    <= LEN_BITS'(204800);
            respawn_reg      <= 6'd60;
            save_int_reg     <= 6'd60;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rsws_pkg::CFG_WORKER_COUNT: worker_count_reg <= cfg_data[4:0];
                rsws_pkg::CFG_JOB_OFFSET:   job_offset_reg   <= cfg_data;
                rsws_pkg::CFG_JOB_LENGTH:   job_length_reg   <= cfg_data;
                rsws_pkg::CFG_MIN_SPLIT:    min_split_reg    <= cfg_data;
                rsws_pkg::CFG_RESPAWN:      respawn_reg      <= cfg_data[5:0];
                rsws_pkg::CFG_SAVE_INT:     save_int_reg     <= cfg_data[5:0];
                default: ;
            endcase
        end
    end

    rsws_pkg::ctrl_cmd_t  cmd;
    rsws_pkg::ctrl_stat_t stat;

    logic [2:0]          verdict;
    logic                save_request, split_made;
    logic [3:0]          donor_id;
    logic [LEN_BITS-1:0] g_off, g_len, d_len;

    rsws_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    rsws_dp #(
        .WORKERS  (WORKERS),
        .LEN_BITS (LEN_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .in_kind        (s_axis_tuser),
        .in_worker_id   (s_axis_tdata[3:0]),
        .in_offset      (s_axis_tdata[LEN_BITS+3:4]),
        .in_length      (s_axis_tdata[2*LEN_BITS+3:LEN_BITS+4]),
        .in_exit        (s_axis_tdata[2*LEN_BITS+4]),
        .worker_count   (worker_count_reg),
        .job_offset     (job_offset_reg),
        .job_length     (job_length_reg),
        .min_split_size (min_split_reg),
        .respawn_limit  (respawn_reg),
        .save_interval  (save_int_reg),
        .save_reset     (6'd60),
        .verdict        (verdict),
        .save_request   (save_request),
        .split_made     (split_made),
        .donor_id       (donor_id),
        .given_offset   (g_off),
        .given_length   (g_len),
        .donor_length   (d_len)
    );

    assign m_axis_tdata = OUT_W'({d_len, g_len, g_off,
                                  donor_id, split_made, save_request, verdict});

`ifndef SYNTH
    a_no_both: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid)) else $error("overlap");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped");
    a_accept_gap: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid)
        else $error("result too early");
`endif

endmodule
